[rtl/sdi12_measure_sequencer_defines.svh]
// ---------------------------------------------------------------------------
// sdi12_measure_sequencer_defines
// Assertion macros used by the sequencer RTL file.
// ---------------------------------------------------------------------------
`ifndef SDI12_MEASURE_SEQUENCER_DEFINES_SVH
`define SDI12_MEASURE_SEQUENCER_DEFINES_SVH
// Assert a property on the rising clock edge, disabled during reset.
`define SDS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SDS_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

[rtl/sdi12ms_pkg.sv]
// ---------------------------------------------------------------------------
// sdi12ms_pkg
// Types and constants of the SDI-12 measurement sequencer.
// ---------------------------------------------------------------------------
`default_nettype none
package sdi12ms_pkg;
    localparam logic       OP_START = 1'b0;
    localparam logic       OP_BYTE  = 1'b1;
    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_VAL  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;
    localparam logic [1:0] PH_FIRST = 2'd0;
    localparam logic [1:0] PH_SREQ  = 2'd1;
    localparam logic [1:0] PH_SEND  = 2'd2;
    localparam logic [1:0] PH_DATA  = 2'd3;
    localparam logic [7:0] CH_M  = 8'h4D;
    localparam logic [7:0] CH_D  = 8'h44;
    localparam logic [7:0] CH_EX = 8'h21;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_PL = 8'h2B;
    localparam logic [7:0] CH_MI = 8'h2D;
    localparam logic [7:0] CH_PT = 8'h2E;
    localparam int MAX_TOKENS = 17;

    typedef enum logic [3:0] {
        S_IDLE, S_CMD0, S_CMD1, S_CMD2, S_HDR, S_SCAN, S_TOKEN, S_EMIT,
        S_TAIL, S_SEND0, S_SEND1, S_SEND2, S_SEND3, S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         tx_char;
        logic [7:0]         sensor_address;
        logic signed [27:0] value_mantissa;
        logic [3:0]         value_decimals;
        logic               value_bad;
        logic [7:0]         value_count;
        logic               last;
    } t_result;

    // Address number to bus character.
    function automatic logic [7:0] to_char(input logic [7:0] a);
        logic [7:0] r;
        if (a <= 8'd9) r = a + 8'h30;
        else if (a <= 8'd35) r = a - 8'd10 + 8'h61;
        else if (a <= 8'd61) r = a - 8'd36 + 8'h41;
        else r = 8'h3A;
        return r;
    endfunction

    // Bus character to address number.
    function automatic logic [7:0] to_addr(input logic [7:0] c);
        logic [7:0] r;
        if (c >= 8'h30 && c <= 8'h39) r = c - 8'h30;
        else if (c >= 8'h61 && c <= 8'h7A) r = c - 8'h61 + 8'd10;
        else if (c >= 8'h41 && c <= 8'h5A) r = c - 8'h41 + 8'd36;
        else r = 8'hFF;
        return r;
    endfunction
endpackage
`default_nettype wire

[rtl/sdi12ms_if.sv]
// ---------------------------------------------------------------------------
// sdi12ms_in_if / sdi12ms_out_if
// Valid/ready channels for input items and result items.
// ---------------------------------------------------------------------------
`default_nettype none
interface sdi12ms_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] rx_byte;
    logic [5:0] target_address;
    modport source (output valid, opcode, rx_byte, target_address, input ready);
    modport sink (input valid, opcode, rx_byte, target_address, output ready);
endinterface

interface sdi12ms_out_if;
    logic                valid;
    logic                ready;
    sdi12ms_pkg::t_result data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[rtl/sdi12ms_ram.sv]
// ---------------------------------------------------------------------------
// sdi12ms_ram
// Single-port-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module sdi12ms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 35
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/sdi12_measure_sequencer.sv]
// ---------------------------------------------------------------------------
// sdi12_measure_sequencer
// SDI-12 recorder-side measure and data request sequencer.
// ---------------------------------------------------------------------------
// Usage:
//  Input channel: opcode 0 starts a measurement at target_address and yields
//  the three characters <addr> M !. Opcode 1 delivers one received bus byte.
//  Output channel: transmit characters, parsed values and a completion marker;
//  'last' flags the final result of each input item.
//  Line walk: a plain received byte is taken in the idle state. The end of a
//  data line walks the stored line twice through the single read port of
//  the line RAM, once to find its end and once to parse it, one character
//  per cycle while the output register does not stall it. The header line
//  reads four characters.
//  Each result is held in an output register until the receiver takes it;
//  the sequencer waits while that register is full and not taken, so a stall on the
//  output only stretches the time of the item at work.
//  Reset clears the phase, counts and framing; the line RAM is not cleared,
//  characters beyond the received length read as zero.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sdi12_measure_sequencer_defines.svh"
module sdi12_measure_sequencer #(
    parameter int LINE_MAX = 35
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    sdi12ms_in_if.sink    in_ch,
    sdi12ms_out_if.source out_ch
);
    localparam int AW = $clog2(LINE_MAX);
    localparam int LW = $clog2(LINE_MAX + 1);

    sdi12ms_pkg::t_state r_state, n_state;

    logic [LW-1:0] r_len, n_len;
    logic          r_in_line, n_in_line;
    logic [1:0]    r_phase, n_phase;
    logic [7:0]    r_laddr, n_laddr;
    logic [7:0]    r_expect, n_expect;
    logic [3:0]    r_dset, n_dset;
    logic [7:0]    r_count, n_count;
    logic [7:0]    r_tchar, n_tchar;

    // line walk and token parse state
    logic [LW-1:0] r_pos, n_pos;       // read address issued
    logic [LW-1:0] r_end, n_end;       // effective line end
    logic          r_rdv, n_rdv;       // read data valid this cycle
    logic [LW-1:0] r_rpos, n_rpos;     // index of read data
    logic [4:0]    r_tokens, n_tokens;
    logic          r_tok_first, n_tok_first;
    logic          r_neg, n_neg;
    logic          r_point, n_point;
    logic          r_bad, n_bad;
    logic [3:0]    r_digits, n_digits;
    logic [3:0]    r_decs, n_decs;
    logic [26:0]   r_mag, n_mag;
    logic signed [15:0] r_delay, n_delay;

    sdi12ms_pkg::t_result r_out, n_out;
    logic                 r_ovalid, n_ovalid;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata, rbyte;

    sdi12ms_ram #(.WIDTH(8), .DEPTH(LINE_MAX)) u_line (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_out;
    assign in_ch.ready  = (r_state == sdi12ms_pkg::S_IDLE) && !r_ovalid;

    logic acc, oslot;
    assign acc   = in_ch.valid && in_ch.ready;
    assign oslot = !r_ovalid || out_ch.ready;
    assign rbyte = (r_rpos < r_len) ? rdata : 8'd0;

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdi12ms_pkg::S_IDLE;
            r_len <= '0; r_in_line <= 1'b0; r_phase <= sdi12ms_pkg::PH_FIRST;
            r_laddr <= '0; r_expect <= '0; r_dset <= '0; r_count <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len <= n_len; r_in_line <= n_in_line; r_phase <= n_phase;
            r_laddr <= n_laddr; r_expect <= n_expect; r_dset <= n_dset;
            r_count <= n_count; r_ovalid <= n_ovalid;
        end
        r_tchar <= n_tchar; r_pos <= n_pos; r_end <= n_end; r_rdv <= n_rdv;
        r_rpos <= n_rpos; r_tokens <= n_tokens; r_tok_first <= n_tok_first;
        r_neg <= n_neg; r_point <= n_point; r_bad <= n_bad; r_digits <= n_digits;
        r_decs <= n_decs; r_mag <= n_mag; r_delay <= n_delay;
        r_out <= n_out;
    end

    // Next state and results
    always_comb begin
        logic [7:0] c;
        logic       sep;
        n_state = r_state; n_len = r_len; n_in_line = r_in_line; n_phase = r_phase;
        n_laddr = r_laddr; n_expect = r_expect; n_dset = r_dset; n_count = r_count;
        n_tchar = r_tchar; n_pos = r_pos; n_end = r_end; n_rdv = 1'b0;
        n_rpos = r_rpos; n_tokens = r_tokens; n_tok_first = r_tok_first;
        n_neg = r_neg; n_point = r_point; n_bad = r_bad; n_digits = r_digits;
        n_decs = r_decs; n_mag = r_mag; n_delay = r_delay;
        n_out = r_out; n_ovalid = r_ovalid && !out_ch.ready;
        we = 1'b0; waddr = r_len[AW-1:0]; wdata = in_ch.rx_byte;
        raddr = r_pos[AW-1:0];
        c = rbyte;
        sep = 1'b0;
        unique case (r_state)
            sdi12ms_pkg::S_IDLE: begin
                if (acc) begin
                    if (in_ch.opcode == sdi12ms_pkg::OP_START) begin
                        n_phase = sdi12ms_pkg::PH_FIRST;
                        n_in_line = 1'b0;
                        n_len = '0;
                        n_tchar = sdi12ms_pkg::to_char({2'b00, in_ch.target_address});
                        n_state = sdi12ms_pkg::S_CMD0;
                    end else if (!r_in_line) begin
                        if (in_ch.rx_byte != 8'd0) begin
                            n_laddr = sdi12ms_pkg::to_addr(in_ch.rx_byte);
                            n_in_line = 1'b1;
                            n_len = '0;
                        end
                    end else if (in_ch.rx_byte == sdi12ms_pkg::CH_CR) begin
                        n_len = r_len;
                    end else if (in_ch.rx_byte != sdi12ms_pkg::CH_LF) begin
                        if (r_len < LW'(LINE_MAX)) begin
                            we = 1'b1;
                            n_len = r_len + 1'b1;
                        end
                    end else begin
                        n_in_line = 1'b0;
                        n_pos = '0;
                        unique case (r_phase)
                            sdi12ms_pkg::PH_FIRST: begin
                                n_delay = '0;
                                n_state = sdi12ms_pkg::S_HDR;
                            end
                            sdi12ms_pkg::PH_DATA: begin
                                n_end = r_len; n_tokens = '0;
                                n_state = sdi12ms_pkg::S_SCAN;
                            end
                            default: begin
                                n_phase = sdi12ms_pkg::PH_DATA;
                                n_state = sdi12ms_pkg::S_SEND0;
                            end
                        endcase
                    end
                end
            end
            sdi12ms_pkg::S_CMD0, sdi12ms_pkg::S_CMD1, sdi12ms_pkg::S_CMD2: begin
                if (oslot) begin
                    n_ovalid = 1'b1;
                    n_out = '0;
                    n_out.kind = sdi12ms_pkg::KIND_TX;
                    if (r_state == sdi12ms_pkg::S_CMD0) begin
                        n_out.tx_char = r_tchar; n_state = sdi12ms_pkg::S_CMD1;
                    end else if (r_state == sdi12ms_pkg::S_CMD1) begin
                        n_out.tx_char = sdi12ms_pkg::CH_M; n_state = sdi12ms_pkg::S_CMD2;
                    end else begin
                        n_out.tx_char = sdi12ms_pkg::CH_EX; n_out.last = 1'b1;
                        n_state = sdi12ms_pkg::S_DONE;
                    end
                end
            end
            sdi12ms_pkg::S_HDR: begin
                // read four header characters, one per cycle
                if (r_pos < LW'(4)) begin
                    n_pos = r_pos + 1'b1;
                    n_rdv = 1'b1;
                    n_rpos = r_pos;
                end
                if (r_rdv) begin
                    unique case (r_rpos[1:0])
                        2'd0: n_delay = 16'sd100 * ($signed({8'd0, c}) - 16'sd48);
                        2'd1: n_delay = r_delay
                                      + 16'sd10 * ($signed({8'd0, c}) - 16'sd48);
                        2'd2: n_delay = r_delay + ($signed({8'd0, c}) - 16'sd48);
                        default: begin
                            n_expect = c - sdi12ms_pkg::CH_0;
                            n_dset = '0; n_count = '0;
                            if (r_delay > 16'sd0) begin
                                n_phase = sdi12ms_pkg::PH_SREQ;
                                n_state = sdi12ms_pkg::S_IDLE;
                            end else begin
                                n_phase = sdi12ms_pkg::PH_DATA;
                                n_state = sdi12ms_pkg::S_SEND0;
                            end
                        end
                    endcase
                end
            end
            sdi12ms_pkg::S_SCAN: begin
                // find the first zero byte, which ends the data
                if (r_rdv && c == 8'd0 && r_rpos < r_end) begin
                    n_end = r_rpos;
                    n_pos = '0;
                    n_state = sdi12ms_pkg::S_TOKEN;
                    n_tok_first = 1'b1;
                end else if (r_pos < r_end) begin
                    n_pos = r_pos + 1'b1;
                    n_rdv = 1'b1;
                    n_rpos = r_pos;
                end else if (!r_rdv) begin
                    n_pos = '0;
                    n_tok_first = 1'b1;
                    n_state = sdi12ms_pkg::S_TOKEN;
                end
            end
            sdi12ms_pkg::S_TOKEN: begin
                // walk one token; a sign past its first byte ends it
                if (r_tok_first && !r_rdv) begin
                    n_neg = 1'b0; n_point = 1'b0; n_bad = 1'b0;
                    n_digits = '0; n_decs = '0; n_mag = '0;
                    if (r_pos >= r_end || r_tokens == 5'(sdi12ms_pkg::MAX_TOKENS)) begin
                        n_state = sdi12ms_pkg::S_TAIL;
                    end else begin
                        n_pos = r_pos + 1'b1; n_rdv = 1'b1; n_rpos = r_pos;
                    end
                end else if (r_rdv) begin
                    sep = (c == sdi12ms_pkg::CH_PL || c == sdi12ms_pkg::CH_MI);
                    if (!r_tok_first && sep) begin
                        n_pos = r_rpos;
                        n_state = sdi12ms_pkg::S_EMIT;
                    end else begin
                        n_tok_first = 1'b0;
                        if (r_tok_first && sep) begin
                            n_neg = (c == sdi12ms_pkg::CH_MI);
                        end else if (c >= 8'h30 && c <= 8'h39) begin
                            if (r_digits >= 4'd8) n_bad = 1'b1;
                            else if (!r_bad) begin
                                n_mag = 27'((r_mag << 3) + (r_mag << 1)) + 27'(c - 8'h30);
                                n_digits = r_digits + 1'b1;
                                if (r_point) n_decs = r_decs + 1'b1;
                            end
                        end else if (c == sdi12ms_pkg::CH_PT && !r_point) begin
                            n_point = 1'b1;
                        end else begin
                            n_bad = 1'b1;
                        end
                        if (r_pos < r_end) begin
                            n_pos = r_pos + 1'b1; n_rdv = 1'b1; n_rpos = r_pos;
                        end else begin
                            n_state = sdi12ms_pkg::S_EMIT;
                        end
                    end
                end
            end
            sdi12ms_pkg::S_EMIT: begin
                if (oslot) begin
                    n_ovalid = 1'b1;
                    n_out = '0;
                    n_out.kind = sdi12ms_pkg::KIND_VAL;
                    n_out.sensor_address = r_laddr;
                    if (r_bad || r_digits == 4'd0) begin
                        n_out.value_bad = 1'b1;
                    end else begin
                        n_out.value_mantissa = r_neg ? -$signed({1'b0, r_mag})
                                                     : $signed({1'b0, r_mag});
                        n_out.value_decimals = r_decs;
                    end
                    if (r_count != 8'hFF) n_count = r_count + 1'b1;
                    n_out.value_count = n_count;
                    n_tokens = r_tokens + 1'b1;
                    n_tok_first = 1'b1;
                    n_state = sdi12ms_pkg::S_TOKEN;
                end
            end
            sdi12ms_pkg::S_TAIL: begin
                if (r_count < r_expect) begin
                    if (r_dset < 4'd9) n_dset = r_dset + 1'b1;
                    n_state = sdi12ms_pkg::S_SEND0;
                end else if (oslot) begin
                    n_ovalid = 1'b1;
                    n_out = '0;
                    n_out.kind = sdi12ms_pkg::KIND_DONE;
                    n_out.sensor_address = r_laddr;
                    n_out.value_count = r_count;
                    n_out.last = 1'b1;
                    n_state = sdi12ms_pkg::S_DONE;
                end
            end
            sdi12ms_pkg::S_SEND0, sdi12ms_pkg::S_SEND1,
            sdi12ms_pkg::S_SEND2, sdi12ms_pkg::S_SEND3: begin
                if (oslot) begin
                    n_ovalid = 1'b1;
                    n_out = '0;
                    n_out.kind = sdi12ms_pkg::KIND_TX;
                    unique case (r_state)
                        sdi12ms_pkg::S_SEND0: begin
                            n_out.tx_char = sdi12ms_pkg::to_char(r_laddr);
                            n_state = sdi12ms_pkg::S_SEND1;
                        end
                        sdi12ms_pkg::S_SEND1: begin
                            n_out.tx_char = sdi12ms_pkg::CH_D;
                            n_state = sdi12ms_pkg::S_SEND2;
                        end
                        sdi12ms_pkg::S_SEND2: begin
                            n_out.tx_char = sdi12ms_pkg::CH_0 + {4'd0, r_dset};
                            n_state = sdi12ms_pkg::S_SEND3;
                        end
                        default: begin
                            n_out.tx_char = sdi12ms_pkg::CH_EX;
                            n_out.last = 1'b1;
                            n_state = sdi12ms_pkg::S_DONE;
                        end
                    endcase
                end
            end
            sdi12ms_pkg::S_DONE: begin
                if (!r_ovalid) n_state = sdi12ms_pkg::S_IDLE;
            end
            default: n_state = sdi12ms_pkg::S_IDLE;
        endcase
    end

    `SDS_ASSERT(a_no_accept_busy, i_clk, i_rst_n,
        in_ch.valid && in_ch.ready |-> r_state == sdi12ms_pkg::S_IDLE, "accept while busy")
    `SDS_ASSERT(a_len_max, i_clk, i_rst_n, r_len <= LW'(LINE_MAX), "line length overflow")
    `SDS_ASSERT(a_dset_max, i_clk, i_rst_n, r_dset <= 4'd9, "dataset digit above 9")
    `SDS_ASSERT(a_hold, i_clk, i_rst_n,
        r_ovalid && !out_ch.ready |=> r_ovalid && $stable(r_out), "result dropped")
endmodule
`default_nettype wire
